// ===== rtl/core/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Types and constants shared by the matrix multiply element files.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 5;
  localparam int PROD_W  = 2 * DATA_W;

  localparam logic [CFG_W-1:0]  INNER_DIM_RST = 5'd9;
  localparam logic [DATA_W-1:0] Q_MAX         = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN         = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic dim_zero;
    logic last_term;
    logic pipe_busy;
  } sts_t;

endpackage

// ===== rtl/core/mme_req_if.sv =====
// ----------------------------------------------------------------------------
// mme_req_if
// Request channel: element writes and product element requests.
// ----------------------------------------------------------------------------
interface mme_req_if;
  logic                               valid;
  logic                               ready;
  logic [mme_pkg::OP_W-1:0]           operation;
  logic [mme_pkg::IDX_W-1:0]          row;
  logic [mme_pkg::IDX_W-1:0]          col;
  logic signed [mme_pkg::DATA_W-1:0]  value;

  modport source (output valid, output operation, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input operation, input row, input col, input value,
                  output ready);
endinterface

// ===== rtl/core/mme_res_if.sv =====
// ----------------------------------------------------------------------------
// mme_res_if
// Result channel: one saturated product element per compute request.
// ----------------------------------------------------------------------------
interface mme_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [mme_pkg::DATA_W-1:0]  product;
  logic                               saturated;

  modport source (output valid, output product, output saturated, input ready);
  modport sink   (input valid, input product, input saturated, output ready);
endinterface

// ===== rtl/core/mme_ram.sv =====
// ----------------------------------------------------------------------------
// mme_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mme_ctrl.sv =====
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer: accepts words, steps the dot product and loads the result.
// ----------------------------------------------------------------------------
module mme_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [mme_pkg::OP_W-1:0]      in_operation,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  mme_pkg::sts_t                 sts,
  output mme_pkg::cmd_t                 cmd
);

  mme_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mme_pkg::ST_IDLE: begin
        if (in_valid && in_operation == mme_pkg::OP_COMPUTE) begin
          state_nxt = sts.dim_zero ? mme_pkg::ST_DRAIN : mme_pkg::ST_ISSUE;
        end
      end
      mme_pkg::ST_ISSUE: begin
        if (sts.last_term) begin
          state_nxt = mme_pkg::ST_DRAIN;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = mme_pkg::ST_FINISH;
        end
      end
      mme_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = mme_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mme_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.wr_a   = in_valid && in_operation == mme_pkg::OP_WR_A;
        cmd.wr_b   = in_valid && in_operation == mme_pkg::OP_WR_B;
        cmd.start  = in_valid && in_operation == mme_pkg::OP_COMPUTE;
      end
      mme_pkg::ST_ISSUE:  cmd.issue = 1'b1;
      mme_pkg::ST_DRAIN:  cmd = '0;
      mme_pkg::ST_FINISH: cmd.load = out_free;
      default:            cmd = '0;
    endcase
  end

  // hold the result until taken; a load only happens when the slot is free
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mme_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/mme_dp.sv =====
// ----------------------------------------------------------------------------
// mme_dp
// Datapath: A and B stores, multiply-accumulate pipe, shift and saturation.
// ----------------------------------------------------------------------------
module mme_dp #(
  parameter int MAX_DIM   = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mme_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [mme_pkg::IDX_W-1:0]         in_row,
  input  logic [mme_pkg::IDX_W-1:0]         in_col,
  input  logic signed [mme_pkg::DATA_W-1:0] in_value,
  input  mme_pkg::cmd_t                     cmd,
  output mme_pkg::sts_t                     sts,
  output logic signed [mme_pkg::DATA_W-1:0] out_product,
  output logic                              out_saturated
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int K_W    = $clog2(MAX_DIM);
  localparam int N_W    = $clog2(MAX_DIM + 1);
  localparam int LIN_W  = 2 * mme_pkg::IDX_W + 1;
  localparam int ACC_W  = mme_pkg::PROD_W + $clog2(MAX_DIM) + 1;
  localparam int DW     = mme_pkg::DATA_W;

  logic [mme_pkg::CFG_W-1:0]  inner_dim_r;
  logic [mme_pkg::IDX_W-1:0]  row_r, col_r;
  logic [N_W-1:0]             n_r, n_nxt;
  logic [K_W-1:0]             k_r, k_nxt;
  logic                       off_r;
  logic                       rd_vld_r, mul_vld_r;
  logic signed [mme_pkg::PROD_W-1:0] mul;
  logic signed [mme_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [DW-1:0]       product_r, product_nxt;
  logic                       saturated_r, saturated_nxt;

  logic                       in_range;
  logic [LIN_W-1:0]           wr_lin, a_lin, b_lin;
  logic [DW-1:0]              a_rdata, b_rdata;

  assign in_range = {1'b0, in_row} < (mme_pkg::IDX_W+1)'(MAX_DIM)
                    && {1'b0, in_col} < (mme_pkg::IDX_W+1)'(MAX_DIM);
  assign wr_lin   = LIN_W'(in_row) * LIN_W'(MAX_DIM) + LIN_W'(in_col);
  assign a_lin    = LIN_W'(row_r) * LIN_W'(MAX_DIM) + LIN_W'(k_r);
  assign b_lin    = LIN_W'(k_r) * LIN_W'(MAX_DIM) + LIN_W'(col_r);

  mme_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a && in_range),
    .waddr (wr_lin[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (a_lin[ADDR_W-1:0]),
    .rdata (a_rdata)
  );

  mme_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b && in_range),
    .waddr (wr_lin[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (b_lin[ADDR_W-1:0]),
    .rdata (b_rdata)
  );

  // clamp the configured dimension to the store size
  assign n_nxt = (inner_dim_r > (mme_pkg::CFG_W)'(MAX_DIM)) ? N_W'(MAX_DIM)
                                                              : inner_dim_r[N_W-1:0];
  assign k_nxt = cmd.start ? '0 : (cmd.issue ? k_r + K_W'(1) : k_r);

  assign mul = $signed(a_rdata) * $signed(b_rdata);

  // terms outside the stores count as zero
  assign prod_nxt = off_r ? '0 : mul;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.start) begin
      acc_nxt = '0;
    end else if (mul_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  assign shifted = acc_r >>> FRAC_BITS;

  always_comb begin
    if ((&shifted[ACC_W-1:DW-1]) || !(|shifted[ACC_W-1:DW-1])) begin
      product_nxt   = shifted[DW-1:0];
      saturated_nxt = 1'b0;
    end else begin
      product_nxt   = shifted[ACC_W-1] ? mme_pkg::Q_MIN : mme_pkg::Q_MAX;
      saturated_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_dim_r <= mme_pkg::INNER_DIM_RST;
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      k_r         <= '0;
    end else begin
      if (cfg_we) begin
        inner_dim_r <= cfg_wdata;
      end
      rd_vld_r  <= cmd.issue;
      mul_vld_r <= rd_vld_r;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= in_row;
      col_r <= in_col;
      n_r   <= n_nxt;
      off_r <= !in_range;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cmd.load) begin
      product_r   <= product_nxt;
      saturated_r <= saturated_nxt;
    end
  end

  assign sts.dim_zero  = (inner_dim_r == '0);
  assign sts.last_term = (N_W'(k_r) + N_W'(1) == n_r);
  assign sts.pipe_busy = rd_vld_r || mul_vld_r;

  assign out_product   = product_r;
  assign out_saturated = saturated_r;

endmodule

// ===== rtl/core/matrix_multiply_element.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_element
// Q16.16 matrix product engine with element-addressed A and B stores.
// ----------------------------------------------------------------------------
// A write word (operation 0 or 1) stores one element of A or B; it is also
// taken while a finished result waits on the output. A compute word returns
// element (row, col) of A*B over n = min(inner_dim, MAX_DIM) terms and
// occupies the block while it runs: one term per cycle goes through the
// single read port of each store and the one shared 32x32 multiplier, then
// the pipe drains and the sum is shifted by FRAC_BITS and saturated into
// the output register. Reading an element that was never written returns an
// undefined value.
// ----------------------------------------------------------------------------
module matrix_multiply_element #(
  parameter int MAX_DIM   = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mme_req_if.sink                   in_req,
  mme_res_if.source                 out_res,
  input  logic                      cfg_we,
  input  logic [mme_pkg::CFG_W-1:0] cfg_wdata
);

  mme_pkg::cmd_t cmd;
  mme_pkg::sts_t sts;

  mme_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_req.valid),
    .in_operation (in_req.operation),
    .in_ready     (in_req.ready),
    .out_valid    (out_res.valid),
    .out_ready    (out_res.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mme_dp #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_row        (in_req.row),
    .in_col        (in_req.col),
    .in_value      (in_req.value),
    .cmd           (cmd),
    .sts           (sts),
    .out_product   (out_res.product),
    .out_saturated (out_res.saturated)
  );

  // a started request keeps the input closed in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_req.ready)
    else $error("input open right after a compute started");

  // never overwrite a result that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_res.valid || out_res.ready))
    else $error("result loaded over a pending result");

  // no word is taken while terms are still in the pipe
  a_pipe_closed: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pipe_busy |-> !in_req.ready)
    else $error("input open while the pipe is busy");

  // issuing a term never overlaps a write, a start or a load
  a_issue_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !(cmd.wr_a || cmd.wr_b || cmd.start || cmd.load))
    else $error("issue overlaps another command");

endmodule

// ===== tb/sv/matrix_multiply_element_tb.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_element_tb
// Self-checking bench for the Q16.16 matrix product engine. Element writes
// and product requests stream in with random gaps and output stalls. A local
// model of the A and B stores predicts each product element over the
// configured inner dimension, and the bench checks every returned element in
// order. Several inner dimension settings are used, including zero, the
// maximum and values above it.
// ----------------------------------------------------------------------------
module matrix_multiply_element_tb;

  localparam int MAX_DIM   = 16;
  localparam int FRAC_BITS = 16;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE    = 30;
  localparam logic [mme_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [127:0] SUM_MAX = 128'sd2147483647;
  localparam logic signed [127:0] SUM_MIN = -128'sd2147483648;

  typedef struct packed {
    logic [mme_pkg::OP_W-1:0]   op;
    logic [mme_pkg::IDX_W-1:0]  row;
    logic [mme_pkg::IDX_W-1:0]  col;
    logic [mme_pkg::DATA_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic signed [mme_pkg::DATA_W-1:0] product;
    logic                              saturated;
  } element_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [mme_pkg::CFG_W-1:0] cfg_wdata;

  mme_req_if req_if ();
  mme_res_if res_if ();

  matrix_multiply_element #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Words waiting to be driven and product elements waiting to come back.
  req_word_t word_q[$];
  element_t  product_q[$];

  // Model state: the element stores and the inner dimension register.
  logic signed [mme_pkg::DATA_W-1:0] a_store [MAX_DIM][MAX_DIM];
  logic signed [mme_pkg::DATA_W-1:0] b_store [MAX_DIM][MAX_DIM];
  logic [mme_pkg::CFG_W-1:0]         dot_len_cfg = mme_pkg::INNER_DIM_RST;

  // Stimulus-side bookkeeping: which entries have been written so far.
  bit a_set [MAX_DIM][MAX_DIM];
  bit b_set [MAX_DIM][MAX_DIM];
  int gen_dim = mme_pkg::INNER_DIM_RST;
  int pushed;

  int errors;
  int src_gap_pct;
  int sink_stall_pct;
  int hold_reqs;

  task automatic report_mismatch(input string msg);
    if (errors < 100) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic element_t dot_product(input logic [mme_pkg::IDX_W-1:0] r,
                                           input logic [mme_pkg::IDX_W-1:0] c);
    logic signed [127:0] acc;
    logic signed [127:0] shifted;
    logic signed [63:0]  term;
    int                  n;
    element_t            res;
    n = (dot_len_cfg > MAX_DIM) ? MAX_DIM : dot_len_cfg;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      term = a_store[r][k] * b_store[k][c];
      acc = acc + {{64{term[63]}}, term};
    end
    shifted = acc >>> FRAC_BITS;
    if (shifted > SUM_MAX) begin
      res.product   = mme_pkg::Q_MAX;
      res.saturated = 1'b1;
    end else if (shifted < SUM_MIN) begin
      res.product   = mme_pkg::Q_MIN;
      res.saturated = 1'b1;
    end else begin
      res.product   = shifted[mme_pkg::DATA_W-1:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  // Request driver: hold a word until taken, then advance or idle.
  always @(posedge clk) begin : drive_proc
    req_word_t w;
    int        gap_left;
    if (!rst_n) begin
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_UNUSED;
      req_if.row       <= '0;
      req_if.col       <= '0;
      req_if.value     <= '0;
      gap_left = 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (word_q.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if ($urandom_range(0, 99) < src_gap_pct) begin
        gap_left = $urandom_range(0, 16);
        req_if.valid <= 1'b0;
      end else begin
        w = word_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.operation <= w.op;
        req_if.row       <= w.row;
        req_if.col       <= w.col;
        req_if.value     <= w.value;
      end
    end
  end

  // Result sink: random stalls plus a long hold when the bench asks for one.
  always @(posedge clk) begin : sink_proc
    int hold_served;
    int hold_left;
    int stall_left;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      hold_served = 0;
      hold_left   = 0;
      stall_left  = 0;
    end else if (hold_served != hold_reqs) begin
      hold_served = hold_reqs;
      hold_left   = LONG_HOLD - 1;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      stall_left = $urandom_range(0, 16);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Track accepted words in the model and check returned elements.
  always @(posedge clk) begin : track_proc
    element_t want;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        case (req_if.operation)
          mme_pkg::OP_WR_A:    a_store[req_if.row][req_if.col] = req_if.value;
          mme_pkg::OP_WR_B:    b_store[req_if.row][req_if.col] = req_if.value;
          mme_pkg::OP_COMPUTE: product_q.push_back(dot_product(req_if.row, req_if.col));
          default: ;
        endcase
      end
      if (res_if.valid && res_if.ready) begin
        if (product_q.size() == 0) begin
          report_mismatch($sformatf("unexpected element %h sat %b",
                                    res_if.product, res_if.saturated));
        end else begin
          want = product_q.pop_front();
          if (res_if.product !== want.product)
            report_mismatch($sformatf("product got %h want %h",
                                      res_if.product, want.product));
          if (res_if.saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %b want %b",
                                      res_if.saturated, want.saturated));
        end
      end
    end
  end

  task automatic push_word(input logic [mme_pkg::OP_W-1:0] op, input int r, input int c,
                           input logic [mme_pkg::DATA_W-1:0] v);
    req_word_t w;
    w.op    = op;
    w.row   = (mme_pkg::IDX_W)'(r);
    w.col   = (mme_pkg::IDX_W)'(c);
    w.value = v;
    word_q.push_back(w);
    if (op == mme_pkg::OP_WR_A) a_set[r][c] = 1'b1;
    if (op == mme_pkg::OP_WR_B) b_set[r][c] = 1'b1;
    if (op != OP_UNUSED) pushed++;
  endtask

  function automatic logic [mme_pkg::DATA_W-1:0] rand_elem();
    logic [mme_pkg::DATA_W-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0, 1:    return r;
      2: begin
        case ($urandom_range(0, 5))
          0:       return mme_pkg::Q_MAX;
          1:       return mme_pkg::Q_MIN;
          2:       return '0;
          3:       return '1;
          4:       return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      6, 7:    return {{8{r[23]}}, r[23:0]};
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  // Fill any entry the dot product touches that was never written, then ask.
  task automatic push_compute(input int r, input int c);
    int n;
    n = (gen_dim > MAX_DIM) ? MAX_DIM : gen_dim;
    for (int k = 0; k < n; k++) begin
      if (!a_set[r][k]) push_word(mme_pkg::OP_WR_A, r, k, rand_elem());
      if (!b_set[k][c]) push_word(mme_pkg::OP_WR_B, k, c, rand_elem());
    end
    push_word(mme_pkg::OP_COMPUTE, r, c, $urandom);
  endtask

  task automatic random_phase(input int count);
    int r;
    int c;
    int n;
    pushed = 0;
    while (pushed < count) begin
      r = $urandom_range(0, MAX_DIM - 1);
      c = $urandom_range(0, MAX_DIM - 1);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6:
          push_word($urandom_range(0, 1) ? mme_pkg::OP_WR_B : mme_pkg::OP_WR_A,
                    r, c, rand_elem());
        7, 8: begin
          // fresh row of A and column of B, then their product element
          n = (gen_dim > MAX_DIM) ? MAX_DIM : gen_dim;
          for (int k = 0; k < n; k++) begin
            push_word(mme_pkg::OP_WR_A, r, k, rand_elem());
            push_word(mme_pkg::OP_WR_B, k, c, rand_elem());
          end
          push_compute(r, c);
        end
        19:
          push_word(OP_UNUSED, r, c, $urandom);
        default:
          push_compute(r, c);
      endcase
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (word_q.size() != 0 || req_if.valid || product_q.size() != 0);
  endtask

  task automatic set_inner_dim(input int v);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= (mme_pkg::CFG_W)'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    dot_len_cfg = (mme_pkg::CFG_W)'(v);
    gen_dim     = v;
    @(negedge clk);
  endtask

  task automatic pick_idling();
    int pick;
    pick = $urandom_range(0, 2);
    src_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
    pick = $urandom_range(0, 2);
    sink_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
  endtask

  initial begin : limit_proc
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main_proc
    logic [mme_pkg::DATA_W-1:0] dir_vals [9];
    int                         dims [11];
    dir_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                 32'h8000_0000};
    dims = '{16, 1, 0, 31, 17, 5, 2, 12, 8, 3, 16};
    errors         = 0;
    hold_reqs      = 0;
    src_gap_pct    = 10;
    sink_stall_pct = 10;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extreme elements at the last row and column, reset dimension.
    for (int k = 0; k < 9; k++) begin
      push_word(mme_pkg::OP_WR_A, MAX_DIM - 1, k, dir_vals[k]);
      push_word(mme_pkg::OP_WR_B, k, MAX_DIM - 1, dir_vals[8 - k]);
    end
    push_word(mme_pkg::OP_COMPUTE, MAX_DIM - 1, MAX_DIM - 1, '0);
    push_word(OP_UNUSED, MAX_DIM - 1, MAX_DIM - 1, '1);
    push_word(OP_UNUSED, 0, 0, '0);
    push_word(mme_pkg::OP_WR_A, MAX_DIM - 1, 0, '0);
    push_word(mme_pkg::OP_WR_A, MAX_DIM - 1, 1, 32'h0000_0002);
    push_word(mme_pkg::OP_COMPUTE, MAX_DIM - 1, MAX_DIM - 1, '1);

    for (int p = 0; p < 11; p++) begin
      set_inner_dim(dims[p]);
      pick_idling();
      // stall the output long enough for the input to back up
      if (p == 0) hold_reqs++;
      random_phase(160);
    end

    // Closing stretch at full rate on both sides.
    wait_idle();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    random_phase(120);
    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
